// ===== sv/aip_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ASCII integer parser: parse phases, per-string state,
// character helpers. No dependencies.
package aip_pkg;

  // Saturation limit for the character and consumed counters.
  localparam int unsigned MAX_COUNT_DEF = 32'd65535;

  localparam int unsigned ACC_W    = 64;
  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  // result tdata: value, count, overflow, padded to whole bytes
  localparam int unsigned RES_BITS = ACC_W + COUNT_W + 1;
  localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd1;

  // Parse modes
  localparam logic [MODE_W-1:0] MODE_SIGNED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUFFIX = 2'd2;

  // Digit code for a character that is no hex digit
  localparam logic [RADIX_W-1:0] DIGIT_NONE = 5'h1f;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_BIG_B = 8'h42;
  localparam logic [CHAR_W-1:0] CH_K     = 8'h6b;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h6d;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h67;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_NUMSTART = 3'd1,
    PH_ZERO     = 3'd2,
    PH_ZEROX    = 3'd3,
    PH_DIGITS   = 3'd4,
    PH_SUFI     = 3'd5,
    PH_SUFB     = 3'd6,
    PH_DONE     = 3'd7
  } aip_phase_e;

  // How the consumed count moves for one character
  typedef enum logic [1:0] {
    CONS_NONE = 2'd0,  // unchanged
    CONS_NEXT = 2'd1,  // through the current character
    CONS_HERE = 2'd2,  // up to, not including, the current character
    CONS_PREV = 2'd3   // one character less than that
  } aip_cons_e;

  typedef struct packed {
    aip_phase_e         phase;
    logic [ACC_W-1:0]   acc;
    logic [RADIX_W-1:0] act_radix;
    logic               negate;
    logic               wrap;
  } aip_state_t;

  function automatic logic [CHAR_W-1:0] lower_of(input logic [CHAR_W-1:0] c);
    lower_of = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] l;
    l = lower_of(c);
    if (l >= 8'h30 && l <= 8'h39) begin
      digit_of = RADIX_W'(l - 8'h30);
    end else if (l >= 8'h61 && l <= 8'h66) begin
      digit_of = RADIX_W'(l - 8'h61 + 8'd10);
    end else begin
      digit_of = DIGIT_NONE;
    end
  endfunction

endpackage

// ===== sv/aip_step.sv =====
`timescale 1ns / 1ps
// Next-state logic for one character of the parser: prefix handling,
// multiply-add of one digit, suffix scaling. Uses aip_pkg.
module aip_step
  import aip_pkg::*;
(
  input  aip_state_t         state_i,
  input  logic [CHAR_W-1:0]  char_i,
  input  logic [RADIX_W-1:0] radix_i,
  input  logic [MODE_W-1:0]  mode_i,
  output aip_state_t         state_o,
  output aip_cons_e          cons_o
);

  localparam int unsigned WIDE_W = ACC_W + RADIX_W;

  logic [CHAR_W-1:0]  lc;
  logic [RADIX_W-1:0] dig;
  logic [RADIX_W-1:0] nc_radix;   // radix used by the digit step this cycle
  logic [RADIX_W-1:0] eff_radix;
  logic [WIDE_W-1:0]  wide;
  logic               do_nc;      // digit/suffix step runs this cycle
  logic               dig_ok;
  logic               suf_k, suf_m, suf_g;
  aip_state_t         pre;        // state after the prefix logic
  aip_cons_e          pre_cons;

  assign lc  = lower_of(char_i);
  assign dig = digit_of(char_i);

  // Prefix and phase handling; picks the radix for the digit step.
  always_comb begin
    pre      = state_i;
    pre_cons = CONS_NONE;
    do_nc    = 1'b0;
    nc_radix = state_i.act_radix;
    case (state_i.phase)
      PH_START, PH_NUMSTART: begin
        if (state_i.phase == PH_START && mode_i == MODE_SIGNED && char_i == CH_MINUS) begin
          pre.negate = 1'b1;
          pre_cons   = CONS_NEXT;
          pre.phase  = PH_NUMSTART;
        end else if (char_i == CH_ZERO && (radix_i == '0 || radix_i == 5'd16)) begin
          pre.phase = PH_ZERO;
        end else begin
          nc_radix      = (radix_i == '0) ? 5'd10 : radix_i;
          pre.act_radix = nc_radix;
          do_nc         = 1'b1;
        end
      end
      PH_ZERO: begin
        if (lc == CH_X && radix_i == 5'd16) begin
          pre.act_radix = 5'd16;
          pre_cons      = CONS_NEXT;
          pre.phase     = PH_DIGITS;
        end else if (lc == CH_X && radix_i == '0) begin
          pre.phase = PH_ZEROX;
        end else begin
          nc_radix      = (radix_i == '0) ? 5'd8 : radix_i;
          pre.act_radix = nc_radix;
          pre_cons      = CONS_HERE;
          do_nc         = 1'b1;
        end
      end
      PH_ZEROX: begin
        if (dig < 5'd16) begin
          nc_radix      = 5'd16;
          pre.act_radix = 5'd16;
          pre_cons      = CONS_HERE;
          do_nc         = 1'b1;
        end else begin
          pre.act_radix = 5'd8;
          pre_cons      = CONS_PREV;
          pre.phase     = PH_DONE;
        end
      end
      PH_DIGITS: begin
        do_nc = 1'b1;
      end
      PH_SUFI: begin
        if (char_i == CH_I) begin
          pre_cons  = CONS_NEXT;
          pre.phase = PH_SUFB;
        end else if (char_i == CH_BIG_B) begin
          pre_cons  = CONS_NEXT;
          pre.phase = PH_DONE;
        end else begin
          pre.phase = PH_DONE;
        end
      end
      PH_SUFB: begin
        if (char_i == CH_BIG_B) begin
          pre_cons = CONS_NEXT;
        end
        pre.phase = PH_DONE;
      end
      default: begin
        pre.phase = PH_DONE;
      end
    endcase
  end

  // One digit: acc * radix + digit, wrap when the top bits are set.
  assign eff_radix = (nc_radix == '0) ? 5'd10 : nc_radix;
  assign dig_ok    = dig < eff_radix;
  assign wide      = WIDE_W'(state_i.acc) * WIDE_W'(eff_radix) + WIDE_W'(dig);

  assign suf_k = (mode_i == MODE_SUFFIX) && (lc == CH_K);
  assign suf_m = (mode_i == MODE_SUFFIX) && (lc == CH_M);
  assign suf_g = (mode_i == MODE_SUFFIX) && (lc == CH_G);

  always_comb begin
    state_o = pre;
    cons_o  = pre_cons;
    if (do_nc) begin
      if (dig_ok) begin
        state_o.acc   = wide[ACC_W-1:0];
        state_o.wrap  = pre.wrap | (wide[WIDE_W-1:ACC_W] != '0);
        state_o.phase = PH_DIGITS;
        cons_o        = CONS_NEXT;
      end else if (suf_k || suf_m || suf_g) begin
        if (suf_g) begin
          state_o.acc  = state_i.acc << 30;
          state_o.wrap = pre.wrap | (state_i.acc[ACC_W-1:ACC_W-30] != '0);
        end else if (suf_m) begin
          state_o.acc  = state_i.acc << 20;
          state_o.wrap = pre.wrap | (state_i.acc[ACC_W-1:ACC_W-20] != '0);
        end else begin
          state_o.acc  = state_i.acc << 10;
          state_o.wrap = pre.wrap | (state_i.acc[ACC_W-1:ACC_W-10] != '0);
        end
        state_o.phase = PH_SUFI;
        cons_o        = CONS_NEXT;
      end else begin
        state_o.phase = PH_DONE;
      end
    end
  end

endmodule

// ===== sv/ascii_integer_parser.sv =====
`timescale 1ns / 1ps
// ASCII integer parser, top level: input register, per-string state,
// result register. Uses aip_pkg and aip_step.
// Usage:
//   Characters of a string stream in on s_axis (one byte per request);
//   a NUL byte ends the string and produces exactly one result request
//   on m_axis: the parsed 64-bit value, the consumed character count and
//   an overflow flag. Other characters produce no result.
//   cfg_* writes the radix (index 0, 0 = deduce from a 0x / 0 prefix) and
//   the parse mode (index 1: unsigned, signed, unsigned with k/m/g suffix).
//   The config port is always ready; write only while no string is in flight.
// Timing:
//   One character per cycle sustained unless a NUL is held back. A character
//   is registered at the input and updates the string state (one 64 x 5
//   multiply-add) on the next edge; a NUL there loads the result register.
// Reset: rst_ni clears radix, mode, string state and both valid flags.
// Stall:
//   While a result waits on m_axis, non-NUL characters keep flowing; a
//   further NUL holds in the input register until the result is taken,
//   and s_axis_tready then drops.
module ascii_integer_parser
  import aip_pkg::*;
#(
  parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] text_char
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [RES_W-1:0]      m_axis_tdata,   // [63:0] parsed_value,
                                                // [79:64] consumed_count,
                                                // [80] overflowed, rest zero
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // counter width from the saturation limit
  localparam int unsigned CW = $clog2(33'(MAX_COUNT) + 33'd1);
  localparam logic [CW-1:0] MaxPos = CW'(MAX_COUNT);

  // configuration
  logic [RADIX_W-1:0] radix_q;
  logic [MODE_W-1:0]  mode_q;

  // input register
  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] in_char_q, in_char_d;

  // string state
  aip_state_t        st_q, st_d, st_step;
  aip_cons_e         cons;
  logic [CW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     stop_q, stop_d, stop_step;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [RES_W-1:0]  out_data_q, out_data_d;

  logic              is_nul;
  logic              fire;        // input register item processed this cycle
  logic [ACC_W-1:0]  res_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
      mode_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RADIX: radix_q <= cfg_data_i[RADIX_W-1:0];
        CFG_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
        default:   ;
      endcase
    end
  end

  // A NUL needs the result register free; other characters never wait.
  assign is_nul        = (in_char_q == CH_NUL);
  assign fire          = in_valid_q && (!is_nul || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    in_char_d  = in_char_q;
    if (fire) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_char_d  = s_axis_tdata;
    end
  end

  aip_step u_step (
    .state_i (st_q),
    .char_i  (in_char_q),
    .radix_i (radix_q),
    .mode_i  (mode_q),
    .state_o (st_step),
    .cons_o  (cons)
  );

  // consumed-count update, saturating at MaxPos
  always_comb begin
    case (cons)
      CONS_NEXT: stop_step = (pos_q == MaxPos) ? MaxPos : pos_q + CW'(1);
      CONS_HERE: stop_step = pos_q;
      CONS_PREV: stop_step = pos_q - CW'(1);
      default:   stop_step = stop_q;
    endcase
  end

  // A NUL never changes the accumulator or wrap flag, so the result takes
  // them straight from the current state.
  assign res_value = st_q.negate ? (ACC_W'(0) - st_q.acc) : st_q.acc;

  always_comb begin
    st_d        = st_q;
    pos_d       = pos_q;
    stop_d      = stop_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      if (is_nul) begin
        out_valid_d = 1'b1;
        out_data_d  = RES_W'({st_q.wrap, COUNT_W'(stop_step), res_value});
        st_d        = '{phase: PH_START, acc: '0, act_radix: '0,
                        negate: 1'b0, wrap: 1'b0};
        pos_d       = '0;
        stop_d      = '0;
      end else begin
        st_d   = st_step;
        pos_d  = (pos_q == MaxPos) ? MaxPos : pos_q + CW'(1);
        stop_d = stop_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PH_START, acc: '0, act_radix: '0,
                       negate: 1'b0, wrap: 1'b0};
      pos_q       <= '0;
      stop_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      pos_q       <= pos_d;
      stop_q      <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_char_q  <= in_char_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== tb/tb_ascii_integer_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ascii_integer_parser: streams strings in,
// predicts every parse result and compares it field by field. Uses aip_pkg.
module tb_ascii_integer_parser;
  import aip_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam int unsigned MAX_CNT       = MAX_COUNT_DEF;
  localparam int unsigned STALL_LIMIT   = 2000;  // idle cycles before giving up
  localparam int unsigned SETTLE_CYCLES = 4;     // quiet time before a register write
  localparam int unsigned RANDOM_CHARS  = 1300;
  localparam int unsigned LONG_CHARS    = 120;
  localparam int unsigned NOT_A_DIGIT   = 256;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 5'd0;
  localparam logic [RADIX_W-1:0] RADIX_UNIT = 5'd1;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_17   = 5'd17;
  localparam logic [RADIX_W-1:0] RADIX_TOP  = 5'd31;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // undefined mode, acts as plain

  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BIG_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_BIG_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_SMALL_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_SMALL_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  typedef struct packed {
    logic               ovf;
    logic [COUNT_W-1:0] count;
    logic [ACC_W-1:0]   value;
  } parse_result_t;

  // Receiver stall styles
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TRICKLE} rx_style_e;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata;    // [7:0] text_char
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_W-1:0]      m_axis_tdata;    // [63:0] parsed_value, [79:64] consumed_count,
                                          // [80] overflowed, rest zero
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ascii_integer_parser #(
    .MAX_COUNT(MAX_CNT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: register copies and per-string state
  // ---------------------------------------------------------------------------
  logic [RADIX_W-1:0] cfg_radix;
  logic [MODE_W-1:0]  cfg_mode;

  aip_phase_e         str_phase;
  logic [ACC_W-1:0]   str_acc;
  logic [RADIX_W-1:0] str_radix;     // latched once the prefix is resolved
  int unsigned        str_pos;       // index of the current character
  int unsigned        str_consumed;  // characters consumed so far
  logic               str_neg;
  logic               str_wrap;

  parse_result_t expected_parses[$];

  int unsigned fail_count = 0;
  int unsigned chars_sent;
  int unsigned idle_cycles = 0;
  int unsigned burst_left;
  int unsigned gap_len;

  rx_style_e   rx_style = RX_OPEN;
  int unsigned rx_age = 0;
  int unsigned rx_span = 50;

  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_BIG_A && c <= CH_BIG_Z) ? (c | CASE_BIT) : c;
  endfunction

  function automatic int unsigned hex_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] l;
    l = fold_lower(c);
    if (l >= CH_ZERO && l <= CH_NINE) return l - CH_ZERO;
    if (l >= CH_SMALL_A && l <= CH_SMALL_F) return l - CH_SMALL_A + 10;
    return NOT_A_DIGIT;
  endfunction

  function automatic void clear_string();
    str_phase    = PH_START;
    str_acc      = '0;
    str_radix    = '0;
    str_pos      = 0;
    str_consumed = 0;
    str_neg      = 1'b0;
    str_wrap     = 1'b0;
  endfunction

  // Consumed count runs through character idx, saturating.
  function automatic void mark_consumed(input int unsigned idx);
    str_consumed = (idx + 1 > MAX_CNT) ? MAX_CNT : idx + 1;
  endfunction

  // One character once the radix is latched: digit, suffix or stop.
  function automatic void feed_number_char(input logic [CHAR_W-1:0] c,
                                           input int unsigned pos);
    int unsigned       d;
    int unsigned       r;
    int unsigned       sh;
    logic [CHAR_W-1:0] l;
    d = hex_value(c);
    r = (str_radix == 0) ? RADIX_DEC : str_radix;
    l = fold_lower(c);
    sh = (l == CH_G) ? 30 : (l == CH_M) ? 20 : (l == CH_K) ? 10 : 0;
    if (d < r) begin
      if (str_acc > ({ACC_W{1'b1}} - ACC_W'(d)) / ACC_W'(r)) str_wrap = 1'b1;
      str_acc = str_acc * ACC_W'(r) + ACC_W'(d);
      mark_consumed(pos);
      str_phase = PH_DIGITS;
    end else if (cfg_mode == MODE_SUFFIX && sh != 0) begin
      // binary magnitude suffix, applies even with no digit before it
      if ((str_acc >> (ACC_W - sh)) != 0) str_wrap = 1'b1;
      str_acc = str_acc << sh;
      mark_consumed(pos);
      str_phase = PH_SUFI;
    end else begin
      str_phase = PH_DONE;
    end
  endfunction

  function automatic void begin_number(input logic [CHAR_W-1:0] c, input int unsigned pos);
    if (c == CH_ZERO && (cfg_radix == RADIX_AUTO || cfg_radix == RADIX_HEX)) begin
      str_phase = PH_ZERO;  // prefix undecided until the next character
    end else begin
      str_radix = (cfg_radix == RADIX_AUTO) ? RADIX_DEC : cfg_radix;
      feed_number_char(c, pos);
    end
  endfunction

  // Advances the shadow by one accepted character; returns 1 with the
  // parse result when the character is the terminator.
  function automatic bit predict_char(input logic [CHAR_W-1:0] c,
                                      output parse_result_t res);
    int unsigned pos;
    pos = str_pos;
    res = '0;
    case (str_phase)
      PH_START: begin
        if (cfg_mode == MODE_SIGNED && c == CH_MINUS) begin
          str_neg = 1'b1;
          mark_consumed(pos);
          str_phase = PH_NUMSTART;
        end else begin
          begin_number(c, pos);
        end
      end
      PH_NUMSTART: begin_number(c, pos);
      PH_ZERO: begin
        if (fold_lower(c) == CH_X && cfg_radix == RADIX_HEX) begin
          str_radix = RADIX_HEX;  // fixed hex skips 0x whatever follows
          mark_consumed(pos);
          str_phase = PH_DIGITS;
        end else if (fold_lower(c) == CH_X && cfg_radix == RADIX_AUTO) begin
          str_phase = PH_ZEROX;
        end else begin
          str_radix = (cfg_radix == RADIX_AUTO) ? RADIX_OCT : cfg_radix;
          mark_consumed(pos - 1);
          str_phase = PH_DIGITS;
          feed_number_char(c, pos);
        end
      end
      PH_ZEROX: begin
        if (hex_value(c) < 16) begin
          str_radix = RADIX_HEX;
          mark_consumed(pos - 1);
          feed_number_char(c, pos);
        end else begin
          // 0x without a hex digit: octal zero, one character consumed
          str_radix = RADIX_OCT;
          mark_consumed(pos - 2);
          str_phase = PH_DONE;
        end
      end
      PH_DIGITS: feed_number_char(c, pos);
      PH_SUFI: begin
        if (c == CH_I) begin
          mark_consumed(pos);
          str_phase = PH_SUFB;
        end else if (c == CH_BIG_B) begin
          mark_consumed(pos);
          str_phase = PH_DONE;
        end else begin
          str_phase = PH_DONE;
        end
      end
      PH_SUFB: begin
        if (c == CH_BIG_B) mark_consumed(pos);
        str_phase = PH_DONE;
      end
      default: str_phase = PH_DONE;
    endcase
    str_pos = (pos < MAX_CNT) ? pos + 1 : MAX_CNT;
    if (c != CH_NUL) return 1'b0;
    res.value = str_neg ? ({ACC_W{1'b0}} - str_acc) : str_acc;
    res.count = str_consumed[COUNT_W-1:0];
    res.ovf   = str_wrap;
    clear_string();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : ready_pattern
    rx_age++;
    if (rx_age >= rx_span) begin
      rx_age   = 0;
      rx_span  = $urandom_range(20, 300);
      rx_style = rx_style_e'($urandom_range(0, 3));
    end
    case (rx_style)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_axis_tready <= ($urandom_range(0, 2) == 0);
      default:  m_axis_tready <= (rx_age % 8 == 0);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    parse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_parses.size() == 0) begin
        $error("unexpected result request: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_parses.pop_front();
        if (m_axis_tdata[ACC_W-1:0] !== want.value) begin
          $error("parsed_value: expected %h, got %h", want.value, m_axis_tdata[ACC_W-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[ACC_W +: COUNT_W] !== want.count) begin
          $error("consumed_count: expected %0d, got %0d", want.count,
                 m_axis_tdata[ACC_W +: COUNT_W]);
          fail_count++;
        end
        if (m_axis_tdata[ACC_W + COUNT_W] !== want.ovf) begin
          $error("overflowed: expected %b, got %b", want.ovf, m_axis_tdata[ACC_W + COUNT_W]);
          fail_count++;
        end
        if (m_axis_tdata[RES_W-1:RES_BITS] !== '0) begin
          $error("padding: expected 0, got %h", m_axis_tdata[RES_W-1:RES_BITS]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any accepted request on any channel resets the idle count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ascii_integer_parser test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // One character request. Bursts of random length with random gaps; valid
  // stays high across a burst so it never drops and rises in one step.
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    parse_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap_len != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
    if (predict_char(ch, res)) expected_parses.push_back(res);
  endtask

  task automatic send_text(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++) send_char(txt[i]);
    send_char(CH_NUL);
  endtask

  // Sender goes quiet until every pending result is back, then lets the
  // pipeline settle so a register write cannot race a character.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (expected_parses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes radix then mode back to back; only called with the block idle.
  task automatic write_config(input logic [CFG_DATA_W-1:0] radix_val,
                              input logic [CFG_DATA_W-1:0] mode_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_RADIX;
    cfg_data_i  <= radix_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_radix = radix_val;
    cfg_index_i <= CFG_MODE;
    cfg_data_i  <= mode_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_mode = mode_val[MODE_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] rand_case(input logic [CHAR_W-1:0] c);
    return ($urandom_range(0, 1) != 0) ? (c & ~CASE_BIT) : c;
  endfunction

  // Random digit below base (up to 16), letters in random case.
  function automatic logic [CHAR_W-1:0] any_digit(input int unsigned base);
    int unsigned v;
    v = $urandom_range(0, base - 1);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return rand_case(CH_SMALL_A + CHAR_W'(v - 10));
  endfunction

  // Mostly well-formed numbers with random content, plus noise and junk.
  task automatic send_random_string();
    logic [CHAR_W-1:0] txt[$];
    int unsigned       kind;
    int unsigned       n;
    int unsigned       base;
    if (cfg_radix == RADIX_AUTO) base = 10;
    else if (cfg_radix < 2) base = 2;   // radix one: '1' stops the parse
    else if (cfg_radix > 16) base = 16;
    else base = cfg_radix;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(0, 6);
      repeat (n) txt.push_back(CHAR_W'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) txt.push_back(CH_MINUS);
      case (kind)
        1: begin  // hex prefix, zero digits exercises the bare 0x case
          txt.push_back(CH_ZERO);
          txt.push_back(rand_case(CH_X));
          n = $urandom_range(0, 18);
          repeat (n) txt.push_back(any_digit(16));
        end
        2: begin  // leading zero, sometimes with 8 or 9 in it
          txt.push_back(CH_ZERO);
          n = $urandom_range(0, 23);
          repeat (n) txt.push_back(any_digit(($urandom_range(0, 3) == 0) ? 10 : 8));
        end
        3, 4: begin  // number with k/m/g suffix and optional i / B tail
          n = $urandom_range(0, 24);
          repeat (n) txt.push_back(any_digit(base));
          case ($urandom_range(0, 2))
            0:       txt.push_back(rand_case(CH_G));
            1:       txt.push_back(rand_case(CH_M));
            default: txt.push_back(rand_case(CH_K));
          endcase
          case ($urandom_range(0, 4))
            0: ;
            1: txt.push_back(CH_I);
            2: begin
              txt.push_back(CH_I);
              txt.push_back(rand_case(CH_BIG_B | CASE_BIT));
            end
            3: txt.push_back(CH_BIG_B);
            default: txt.push_back(CH_I & ~CASE_BIT);
          endcase
        end
        default: begin
          n = $urandom_range(1, 21);
          repeat (n) txt.push_back(any_digit(base));
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) txt.push_back(CHAR_W'($urandom_range(1, 255)));
      end
    end
    foreach (txt[i]) send_char(txt[i]);
    send_char(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Radix deduction: hex, 0x without a hex digit, octal, decimal, empty.
  task automatic test_prefix_deduction();
    write_config(RADIX_AUTO, MODE_PLAIN);
    send_text("0X1f");
    send_text("0xZ");
    send_text("07");
    send_text("9");
    send_text("");
    drain_results();
  endtask

  // Leading minus: alone it still counts; in hex it wraps to two's complement.
  task automatic test_signed_minus();
    write_config(RADIX_HEX, MODE_SIGNED);
    send_text("-");
    send_text("-0xq");
    send_text("-1-");
    drain_results();
  endtask

  // Suffix scaling, with no digits before it, and an i/B tail.
  task automatic test_binary_suffix();
    write_config(RADIX_AUTO, MODE_SUFFIX);
    send_text("kiB");
    send_text("3G");
    send_text("1mB");
    drain_results();
  endtask

  // Radix one, radix above 16, undefined mode with upper data bits set.
  task automatic test_odd_radix();
    write_config(RADIX_UNIT, {3'b111, MODE_SPARE});
    send_text("01");
    drain_results();
    write_config(RADIX_TOP, MODE_PLAIN);
    send_text("fF");
    drain_results();
  endtask

  // 64-bit wrap during accumulation.
  task automatic test_wrap_on_overflow();
    write_config(RADIX_DEC, MODE_PLAIN);
    send_text("99999999999999999999");
    drain_results();
  endtask

  // Long digit run: the count climbs to 120 while the value wraps.
  task automatic test_long_string();
    int unsigned i;
    write_config(RADIX_DEC, MODE_PLAIN);
    for (i = 0; i < LONG_CHARS; i++) send_char(any_digit(10));
    send_char(CH_NUL);
    drain_results();
  endtask

  // Random strings across many register settings, extremes first.
  task automatic test_random_strings();
    int unsigned        start_count;
    int unsigned        phase_idx;
    logic [RADIX_W-1:0] r;
    logic [MODE_W-1:0]  m;
    start_count = chars_sent;
    phase_idx   = 0;
    while (chars_sent - start_count < RANDOM_CHARS || phase_idx < 10) begin
      case (phase_idx)
        0: begin r = RADIX_AUTO; m = MODE_PLAIN;  end
        1: begin r = RADIX_AUTO; m = MODE_SIGNED; end
        2: begin r = RADIX_AUTO; m = MODE_SUFFIX; end
        3: begin r = RADIX_HEX;  m = MODE_SUFFIX; end
        4: begin r = RADIX_OCT;  m = MODE_SIGNED; end
        5: begin r = RADIX_TOP;  m = MODE_SPARE;  end
        6: begin r = RADIX_UNIT; m = MODE_PLAIN;  end
        7: begin r = RADIX_DEC;  m = MODE_SUFFIX; end
        8: begin r = RADIX_17;   m = MODE_SIGNED; end
        default: begin
          case ($urandom_range(0, 4))
            0:       r = RADIX_AUTO;
            1:       r = RADIX_HEX;
            2:       r = RADIX_DEC;
            default: r = RADIX_W'($urandom_range(0, 31));
          endcase
          m = MODE_W'($urandom_range(0, 3));
        end
      endcase
      write_config(r, {3'($urandom_range(0, 7)), m});
      repeat ($urandom_range(4, 8)) begin
        send_random_string();
        if ($urandom_range(0, 30) == 0) drain_results();  // mid-phase pause
      end
      drain_results();
      phase_idx++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    cfg_radix   = RADIX_AUTO;
    cfg_mode    = MODE_PLAIN;
    chars_sent  = 0;
    burst_left  = 0;
    gap_len     = 0;
    clear_string();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_prefix_deduction();
    test_signed_minus();
    test_binary_suffix();
    test_odd_radix();
    test_wrap_on_overflow();
    test_long_string();
    test_random_strings();
    drain_results();

    if (expected_parses.size() != 0) begin
      $error("%0d expected results never arrived", expected_parses.size());
    end
    if (fail_count == 0 && expected_parses.size() == 0) begin
      $display("ascii_integer_parser test passed");
    end else begin
      $display("ascii_integer_parser test failed");
    end
    $finish;
  end

endmodule
